@@ rtl/stb_pkg.sv @@
// Shared types and constants for the simulated-time barrier coordinator.
// Used by stb_table and simulated_time_barrier; depends on nothing.
`timescale 1ns / 1ps

package stb_pkg;

	localparam int PARTICIPANTS = 16;
	localparam int IDX_W = $clog2(PARTICIPANTS);
	localparam int CNT_W = $clog2(PARTICIPANTS + 1);
	localparam int STEP_W = 64;

	// Request kinds carried in the input tuser.
	localparam logic [1:0] FUNC_REPORT = 2'd0;
	localparam logic [1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [1:0] FUNC_STOP = 2'd2;

	// Participant status codes.
	localparam logic [1:0] STAT_WORKING = 2'd0;
	localparam logic [1:0] STAT_OUT_OF_SYNC = 2'd1;
	localparam logic [1:0] STAT_WAITING = 2'd2;
	localparam logic [1:0] STAT_REALTIME = 2'd3;

	// Advance outcome codes.
	localparam logic [1:0] ADV_DONE = 2'd0;
	localparam logic [1:0] ADV_NO_DATA = 2'd1;
	localparam logic [1:0] ADV_OUT_OF_SYNC = 2'd2;
	localparam logic [1:0] ADV_INACTIVE = 2'd3;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [1:0]        status;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
	} tbl_rd_t;

	// Result word; the last member sits in the lowest bits of tdata.
	typedef struct packed {
		logic              pad;
		logic [STEP_W-1:0] cur_time;
		logic              stop_sent;
		logic [STEP_W-1:0] trig_time;
		logic              trig_valid;
		logic [1:0]        outcome;
		logic [1:0]        status;
		logic              kept;
	} result_t;

endpackage

@@ rtl/stb_table.sv @@
// Participant table: a synchronous memory of step and status words with
// per-entry valid flags in flip-flops. Depends on stb_pkg.
`timescale 1ns / 1ps

module stb_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [stb_pkg::IDX_W-1:0] rd_addr,
	output stb_pkg::tbl_rd_t        rd,
	input  stb_pkg::tbl_wr_t        wr
);

	stb_pkg::entry_t                  mem [stb_pkg::PARTICIPANTS];
	logic [stb_pkg::PARTICIPANTS-1:0] valid_q;
	stb_pkg::entry_t                  rd_data_q;
	logic                             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd.valid = rd_valid_q;
	assign rd.data = rd_data_q;

endmodule

@@ rtl/simulated_time_barrier.sv @@
// Lock-step simulated-time barrier coordinator, top level.
// Depends on stb_pkg and stb_table.
`timescale 1ns / 1ps
//
// Channel | Dir | Signals                        | Word
// s       | in  | s_tvalid s_tready s_tdata s_tuser | one request
// m       | out | m_tvalid m_tready m_tdata      | one result per request
// cfg     | in  | cfg_valid cfg_ready cfg_data   | simulated_mode register
//
// A ready report goes from acceptance to the next acceptance through a table read,
// a compare and write back, then hand-off to the output register.
// An advance request reads the table twice, once for the minimum and once to
// mark entries working; a refused advance skips the second pass.
// Stop, unknown and inactive requests go straight to the output hand-off.
// Reset clears the valid flags at once; the table memory needs no clearing.
// A result waiting in the output register does not block the next request;
// only a second result finishing before the first is taken waits.

module simulated_time_barrier (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // participant[3:0], requested_step[67:4], zero[71:68]
	input  logic [1:0]   s_tuser,  // func[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// report_kept[0], assigned_status[2:1], advance_outcome[4:3], trigger_valid[5],
	// trigger_time[69:6], stop_sent[70], current_time[134:71], zero[135]
	output logic [135:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REPORT = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_MARK   = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	localparam logic [stb_pkg::CNT_W-1:0] LAST_CNT = stb_pkg::CNT_W'(stb_pkg::PARTICIPANTS);

	state_t                         state_q;
	logic                           running_q;
	logic                           mode_q;
	logic [stb_pkg::STEP_W-1:0]     sim_time_q;
	logic [stb_pkg::STEP_W-1:0]     item_step_q;
	logic [stb_pkg::IDX_W-1:0]      item_idx_q;
	logic [stb_pkg::CNT_W-1:0]      cnt_q;
	logic                           issue_s1;
	logic [stb_pkg::IDX_W-1:0]      idx_s1;
	logic                           have_q;
	logic [stb_pkg::STEP_W-1:0]     low_q;
	stb_pkg::result_t               res_q;
	stb_pkg::result_t               out_q;
	logic                           out_valid_q;

	logic                           accept;
	logic [3:0]                     in_participant;
	logic [stb_pkg::STEP_W-1:0]     in_step;
	logic                           in_range;
	logic                           scanning;
	logic                           scan_rd;
	logic                           rd_en;
	logic [stb_pkg::IDX_W-1:0]      rd_addr;
	stb_pkg::tbl_rd_t               rd;
	stb_pkg::tbl_wr_t               wr;
	logic [stb_pkg::STEP_W-1:0]     stored_step;
	logic                           rpt_keep;
	logic [1:0]                     rpt_status;
	logic                           fin_go;
	stb_pkg::result_t               res_idle;
	stb_pkg::result_t               res_next;

	assign in_participant = s_tdata[3:0];
	assign in_step = s_tdata[67:4];
	assign in_range = 32'(in_participant) < 32'(stb_pkg::PARTICIPANTS);
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign fin_go = !out_valid_q || m_tready;

	assign scanning = (state_q == ST_SCAN) || (state_q == ST_MARK);
	assign scan_rd = scanning && (cnt_q < LAST_CNT);

	always_comb begin
		rd_en = scan_rd;
		rd_addr = cnt_q[stb_pkg::IDX_W-1:0];
		if (state_q == ST_IDLE) begin
			rd_en = accept && (s_tuser == stb_pkg::FUNC_REPORT);
			rd_addr = stb_pkg::IDX_W'(in_participant);
		end
	end

	// Ready report classification against the entry just read.
	assign stored_step = rd.valid ? rd.data.step : '0;
	assign rpt_keep = item_step_q >= stored_step;

	always_comb begin
		priority if (!mode_q) begin
			rpt_status = stb_pkg::STAT_REALTIME;
		end else if (item_step_q == sim_time_q) begin
			rpt_status = stb_pkg::STAT_WORKING;
		end else if (item_step_q < sim_time_q) begin
			rpt_status = stb_pkg::STAT_OUT_OF_SYNC;
		end else begin
			rpt_status = stb_pkg::STAT_WAITING;
		end
	end

	always_comb begin
		wr = '0;
		if (state_q == ST_REPORT) begin
			wr.en = rpt_keep;
			wr.addr = item_idx_q;
			wr.data.step = item_step_q;
			wr.data.status = rpt_status;
		end else if (state_q == ST_MARK) begin
			// Entries read in the previous cycle that sit at the new time are rewritten as working behind the read pointer.
			wr.en = issue_s1 && rd.valid && (rd.data.step == sim_time_q)
				&& (rd.data.status != stb_pkg::STAT_WORKING);
			wr.addr = idx_s1;
			wr.data.step = rd.data.step;
			wr.data.status = stb_pkg::STAT_WORKING;
		end
	end

	always_comb begin
		res_idle = '0;
		res_idle.outcome = stb_pkg::ADV_INACTIVE;
		res_idle.cur_time = sim_time_q;
	end

	always_comb begin
		res_next = res_q;
		unique case (state_q)
			ST_IDLE: begin
				res_next = res_idle;
				res_next.stop_sent = (s_tuser == stb_pkg::FUNC_STOP);
			end
			ST_REPORT: begin
				res_next = res_idle;
				res_next.kept = rpt_keep;
				res_next.status = rpt_keep ? rpt_status : stb_pkg::STAT_WORKING;
			end
			ST_DECIDE: begin
				res_next = res_idle;
				if (!have_q) begin
					res_next.outcome = stb_pkg::ADV_NO_DATA;
				end else if (low_q < sim_time_q) begin
					res_next.outcome = stb_pkg::ADV_OUT_OF_SYNC;
				end
			end
			ST_MARK: begin
				res_next = res_idle;
				res_next.outcome = stb_pkg::ADV_DONE;
				res_next.trig_valid = 1'b1;
				res_next.trig_time = sim_time_q;
			end
			ST_SCAN, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	stb_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd      (rd),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			running_q <= 1'b1;
			mode_q <= 1'b1;
			sim_time_q <= '0;
			cnt_q <= '0;
			issue_s1 <= 1'b0;
			have_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			issue_s1 <= scan_rd;
			if (scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if ((state_q == ST_SCAN) && issue_s1 && rd.valid
				&& (!have_q || (rd.data.step < low_q))) begin
				have_q <= 1'b1;
			end
			if ((state_q == ST_FIN) && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						have_q <= 1'b0;
						unique case (s_tuser)
							stb_pkg::FUNC_REPORT: begin
								state_q <= (running_q && in_range) ? ST_REPORT : ST_FIN;
							end
							stb_pkg::FUNC_ADVANCE: begin
								state_q <= (mode_q && running_q) ? ST_SCAN : ST_FIN;
							end
							stb_pkg::FUNC_STOP: begin
								running_q <= 1'b0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_REPORT: state_q <= ST_FIN;
				ST_SCAN: begin
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (have_q && (low_q >= sim_time_q)) begin
						sim_time_q <= low_q;
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MARK: begin
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[stb_pkg::IDX_W-1:0];
		if ((state_q == ST_SCAN) && issue_s1 && rd.valid
			&& (!have_q || (rd.data.step < low_q))) begin
			low_q <= rd.data.step;
		end
		if ((state_q == ST_FIN) && fin_go) begin
			out_q <= res_q;
		end
		if (state_q == ST_IDLE) begin
			item_step_q <= in_step;
			item_idx_q <= stb_pkg::IDX_W'(in_participant);
		end
		res_q <= res_next;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == stb_pkg::FUNC_STOP)) |=> !running_q)
		else $error("stop request did not halt the coordinator");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		sim_time_q >= $past(sim_time_q))
		else $error("simulated time moved backward");

	a_trigger_time: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.trig_valid) |-> (out_q.trig_time == out_q.cur_time))
		else $error("trigger time differs from current time");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> ((state_q == ST_REPORT) || (state_q == ST_MARK)))
		else $error("table written outside report or mark phase");

	a_kept_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.kept) |-> (out_q.outcome == stb_pkg::ADV_INACTIVE))
		else $error("stored report carries an advance outcome");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the simulated-time barrier coordinator.
// Depends on stb_pkg and simulated_time_barrier; every result word is checked against
// a typed-in expectation or a cycle-free predictor; directed rows frame random traffic.
`timescale 1ns / 1ps

module testbench;

	typedef logic [stb_pkg::STEP_W-1:0] field_t;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam field_t STEP_MAX = '1;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 60;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic                      mode;
		logic [1:0]                func;
		logic [stb_pkg::IDX_W-1:0] who;
		field_t                    step;
		bit                        fixed;
		stb_pkg::result_t          want;
	} step_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_data = 1'b0;

	// Sideband that travels with each request word: a typed-in expectation.
	bit               drv_fixed = 1'b0;
	stb_pkg::result_t drv_want = '0;

	// Predictor state.
	logic   part_valid [stb_pkg::PARTICIPANTS];
	field_t part_step [stb_pkg::PARTICIPANTS];
	logic [1:0] part_status [stb_pkg::PARTICIPANTS];
	field_t now_time = '0;
	logic   active = 1'b1;
	logic   sim_mode = 1'b1;

	stb_pkg::result_t pending_results [$];
	step_row_t        directed_rows [$];
	int               mismatches = 0;
	int               idle_cycles = 0;
	int               sink_cycles = 0;
	int               stall_left = 0;
	bit               fast_mode = 1'b0;
	logic             mode_set = 1'b1;

	simulated_time_barrier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < stb_pkg::PARTICIPANTS; i++) begin
			part_valid[i] = 1'b0;
			part_step[i] = '0;
			part_status[i] = stb_pkg::STAT_WORKING;
		end
	end

	function automatic stb_pkg::result_t barrier_predict(logic [1:0] func,
			logic [stb_pkg::IDX_W-1:0] who, field_t req);
		stb_pkg::result_t r;
		field_t stored;
		field_t lowest;
		logic [1:0] st;
		bit have;
		r = '0;
		r.outcome = stb_pkg::ADV_INACTIVE;
		lowest = '0;
		have = 1'b0;
		unique case (func)
			stb_pkg::FUNC_REPORT: begin
				if (active) begin
					stored = part_valid[who] ? part_step[who] : '0;
					if (req >= stored) begin
						if (!sim_mode)
							st = stb_pkg::STAT_REALTIME;
						else if (req == now_time)
							st = stb_pkg::STAT_WORKING;
						else if (req < now_time)
							st = stb_pkg::STAT_OUT_OF_SYNC;
						else
							st = stb_pkg::STAT_WAITING;
						part_valid[who] = 1'b1;
						part_step[who] = req;
						part_status[who] = st;
						r.kept = 1'b1;
						r.status = st;
					end
				end
			end
			stb_pkg::FUNC_ADVANCE: begin
				if (sim_mode && active) begin
					for (int i = 0; i < stb_pkg::PARTICIPANTS; i++) begin
						if (part_valid[i] && (!have || part_step[i] < lowest)) begin
							lowest = part_step[i];
							have = 1'b1;
						end
					end
					if (!have) begin
						r.outcome = stb_pkg::ADV_NO_DATA;
					end else if (lowest < now_time) begin
						r.outcome = stb_pkg::ADV_OUT_OF_SYNC;
					end else begin
						now_time = lowest;
						for (int i = 0; i < stb_pkg::PARTICIPANTS; i++)
							if (part_valid[i] && part_step[i] == now_time)
								part_status[i] = stb_pkg::STAT_WORKING;
						r.outcome = stb_pkg::ADV_DONE;
						r.trig_valid = 1'b1;
						r.trig_time = now_time;
					end
				end
			end
			stb_pkg::FUNC_STOP: begin
				r.stop_sent = 1'b1;
				active = 1'b0;
			end
			FUNC_UNKNOWN: begin
			end
		endcase
		r.cur_time = now_time;
		return r;
	endfunction

	function automatic void compare_field(string name, field_t want, field_t got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Scoreboard: expectations are queued at request acceptance and retired
	// in order at result acceptance.
	always @(posedge clk) begin : score
		stb_pkg::result_t predicted;
		stb_pkg::result_t want;
		stb_pkg::result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sim_mode = cfg_data;
			if (s_tvalid && s_tready) begin
				predicted = barrier_predict(s_tuser, s_tdata[3:0], s_tdata[67:4]);
				pending_results.push_back(drv_fixed ? drv_want : predicted);
			end
			if (m_tvalid && m_tready) begin
				got = stb_pkg::result_t'(m_tdata);
				if (pending_results.size() == 0) begin
					$error("result word %0h arrived with no request outstanding", m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					compare_field("report_kept", field_t'(want.kept), field_t'(got.kept));
					compare_field("assigned_status", field_t'(want.status),
						field_t'(got.status));
					compare_field("advance_outcome", field_t'(want.outcome),
						field_t'(got.outcome));
					compare_field("trigger_valid", field_t'(want.trig_valid),
						field_t'(got.trig_valid));
					compare_field("trigger_time", want.trig_time, got.trig_time);
					compare_field("stop_sent", field_t'(want.stop_sent),
						field_t'(got.stop_sent));
					compare_field("current_time", want.cur_time, got.cur_time);
					compare_field("pad", '0, field_t'(got.pad));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (fast_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Result sink with random back-pressure and occasional full-speed stretches.
	always @(posedge clk) begin
		sink_cycles <= sink_cycles + 1;
		if (sink_cycles % 300 == 0)
			fast_mode <= ($urandom_range(0, 3) == 0);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	function automatic step_row_t free_row(logic mode, logic [1:0] func,
			logic [stb_pkg::IDX_W-1:0] who, field_t step);
		step_row_t row;
		row.mode = mode;
		row.func = func;
		row.who = who;
		row.step = step;
		row.fixed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic step_row_t fixed_row(logic mode, logic [1:0] func,
			logic [stb_pkg::IDX_W-1:0] who, field_t step, logic kept, logic [1:0] status,
			logic [1:0] outcome, logic trig, field_t now);
		step_row_t row;
		row = free_row(mode, func, who, step);
		row.fixed = 1'b1;
		row.want.kept = kept;
		row.want.status = status;
		row.want.outcome = outcome;
		row.want.trig_valid = trig;
		row.want.trig_time = trig ? now : '0;
		row.want.cur_time = now;
		return row;
	endfunction

	task automatic send_item(input step_row_t row, input int gap);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, row.step, row.who};
		s_tuser <= row.func;
		drv_fixed <= row.fixed;
		drv_want <= row.want;
		do @(posedge clk); while (!s_tready);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The first edge lets the scoreboard queue the word accepted at the last edge.
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_set = mode;
	endtask

	task automatic run_rows(input int first, input int last);
		for (int k = first; k <= last; k++) begin
			if (directed_rows[k].mode != mode_set) begin
				wait_results_done();
				write_mode(directed_rows[k].mode);
			end
			send_item(directed_rows[k], pick_gap());
		end
	endtask

	// Most reports land at or just past the current time so that advances keep
	// succeeding; some are late, and wide phases use full-width timesteps.
	task automatic run_random(input logic mode, input int count, input bit wide);
		step_row_t row;
		int roll;
		wait_results_done();
		write_mode(mode);
		for (int k = 0; k < count; k++) begin
			row = free_row(mode, stb_pkg::FUNC_REPORT, '0, '0);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				row.func = FUNC_UNKNOWN;
				row.who = stb_pkg::IDX_W'($urandom_range(0, stb_pkg::PARTICIPANTS - 1));
				row.step = {$urandom, $urandom};
			end else if (roll < 30) begin
				row.func = stb_pkg::FUNC_ADVANCE;
				row.who = stb_pkg::IDX_W'($urandom_range(0, stb_pkg::PARTICIPANTS - 1));
			end else if (wide) begin
				row.who = stb_pkg::IDX_W'($urandom_range(0, stb_pkg::PARTICIPANTS - 2));
				if ($urandom_range(0, 1) == 0)
					row.step = {$urandom, $urandom};
				else
					row.step = now_time + field_t'($urandom_range(0, 4));
			end else begin
				row.who = stb_pkg::IDX_W'($urandom_range(0, stb_pkg::PARTICIPANTS - 1));
				roll = $urandom_range(0, 99);
				if (roll < 55)
					row.step = now_time + field_t'($urandom_range(0, 4));
				else if (roll < 75)
					row.step = (part_valid[row.who] ? part_step[row.who] : now_time)
						+ field_t'($urandom_range(0, 2));
				else if (roll < 90)
					row.step = (now_time > field_t'(4))
						? now_time - field_t'($urandom_range(1, 4))
						: field_t'($urandom_range(0, 4));
				else begin
					// Participant 15 holds the largest timestep, so these are stale.
					row.who = stb_pkg::IDX_W'(stb_pkg::PARTICIPANTS - 1);
					row.step = {$urandom, $urandom};
				end
			end
			send_item(row, pick_gap());
			if ($urandom_range(0, 49) == 0)
				wait_results_done();
		end
	endtask

	initial begin : stimulus
		int tail_start;
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_NO_DATA, 1'b0, 64'd0));
		directed_rows.push_back(fixed_row(1'b1, FUNC_UNKNOWN, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd0));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd0, 64'd0, 1'b1,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd0));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd15, STEP_MAX, 1'b1,
			stb_pkg::STAT_WAITING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd0));
		// A minimum equal to the current time still sends the trigger.
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_DONE, 1'b1, 64'd0));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd0, 64'd3, 1'b1,
			stb_pkg::STAT_WAITING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd0));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd15, 64'd2, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd0));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_DONE, 1'b1, 64'd3));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd1, 64'd1, 1'b1,
			stb_pkg::STAT_OUT_OF_SYNC, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_OUT_OF_SYNC, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd1, 64'd3, 1'b1,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd0, 64'd3, 1'b1,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_REPORT, 4'd2, 64'd4, 1'b1,
			stb_pkg::STAT_WAITING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_DONE, 1'b1, 64'd3));
		directed_rows.push_back(free_row(1'b1, stb_pkg::FUNC_REPORT, 4'd2, 64'd10));
		directed_rows.push_back(free_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0));
		directed_rows.push_back(fixed_row(1'b0, stb_pkg::FUNC_REPORT, 4'd3, 64'd7, 1'b1,
			stb_pkg::STAT_REALTIME, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b0, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b0, FUNC_UNKNOWN, 4'd0, 64'd0, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		directed_rows.push_back(fixed_row(1'b0, stb_pkg::FUNC_REPORT, 4'd0, 64'd2, 1'b0,
			stb_pkg::STAT_WORKING, stb_pkg::ADV_INACTIVE, 1'b0, 64'd3));
		tail_start = directed_rows.size();
		// Closing rows: stop, then everything that a stopped coordinator ignores.
		directed_rows.push_back(free_row(1'b1, stb_pkg::FUNC_STOP, 4'd0, 64'd0));
		directed_rows.push_back(free_row(1'b1, stb_pkg::FUNC_REPORT, 4'd5, STEP_MAX));
		directed_rows.push_back(free_row(1'b1, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0));
		directed_rows.push_back(free_row(1'b0, stb_pkg::FUNC_ADVANCE, 4'd0, 64'd0));
		directed_rows.push_back(free_row(1'b0, stb_pkg::FUNC_STOP, 4'd0, 64'd0));
		directed_rows.push_back(free_row(1'b0, FUNC_UNKNOWN, 4'd0, 64'd0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b1);
		run_rows(0, tail_start - 1);
		run_random(1'b1, 100, 1'b0);
		run_random(1'b0, 90, 1'b0);
		run_random(1'b1, 110, 1'b0);
		run_random(1'b0, 80, 1'b0);
		run_random(1'b1, 100, 1'b0);
		run_random(1'b1, 60, 1'b1);
		run_rows(tail_start, directed_rows.size() - 1);
		wait_results_done();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result words never arrived", pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/stb_pkg.sv
rtl/stb_table.sv
rtl/simulated_time_barrier.sv
tb/testbench.sv
